// ===== sv/gif_lzw_decoder_defines.svh =====
// Assertion macros for the GIF LZW decoder top level.
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gif_lzw_decoder: assertion failed");
`define GLD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("gif_lzw_decoder: reset assertion failed");
`else
`define GLD_ASSERT(lbl, prop)
`define GLD_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/gld_pkg.sv =====
// Types and constants shared by the GIF LZW decoder modules.
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;
    localparam int TABLE_ENTRIES    = 4096;
    localparam int TABLE_BITS       = 12;
    localparam int MAX_CODE_BITS    = 12;
    localparam int PIXEL_INDEX_BITS = 22;
    localparam int CODE_BITS        = 13;
    localparam int COUNT_BITS       = 23;
    localparam int STEP_CAP         = 64;

    localparam logic [CODE_BITS-1:0] NO_CODE = 13'h1FFF;

    localparam logic [1:0] STATUS_PIXEL    = 2'd0;
    localparam logic [1:0] STATUS_FINISHED = 2'd1;
    localparam logic [1:0] STATUS_BAD_CODE = 2'd2;

    localparam logic CFG_MIN_CODE_SIZE = 1'b0;
    localparam logic CFG_PIXEL_LIMIT   = 1'b1;

    typedef struct packed {
        logic       is_term;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [7:0]                  pixel_value;
        logic [PIXEL_INDEX_BITS-1:0] pixel_index;
    } result_t;
endpackage
`default_nettype wire

// ===== sv/gif_lzw_decoder.sv =====
// Top level of the GIF LZW decoder: input queue, decoder core and output packing.
// Each input beat (a data byte, or the terminator flagged on s_tuser) is queued and then
// handled as one step by the decoder core, which returns zero to 64 result beats for it and
// holds the rest of a long string for later steps. Each pixel popped from the string stack
// passes the DRAIN and POP states (POP waits on a stalled output), and each dictionary entry
// walked for a code passes the WALK and WALKD states, as the prefix and suffix memories have
// one registered read port. The block needs no clearing pass after reset.
// Configuration writes must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "gif_lzw_decoder_defines.svh"
module gif_lzw_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [22:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] end_of_data
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] pixel_value, [29:8] pixel_index, zero above
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast
);
    logic             item_valid;
    logic             item_ready;
    gld_pkg::item_t   item;
    gld_pkg::result_t result;

    gld_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    gld_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, result.pixel_index, result.pixel_value};
    assign m_tuser = result.status;

    `GLD_ASSERT(a_status_legal, m_tvalid |-> (m_tuser <= gld_pkg::STATUS_BAD_CODE))
    `GLD_ASSERT(a_end_is_last, (m_tvalid && m_tuser != gld_pkg::STATUS_PIXEL) |-> m_tlast)
    `GLD_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid)
endmodule
`default_nettype wire

// ===== sv/gld_front.sv =====
// Input front end: classifies each input beat and queues it for the decoder core.
`timescale 1ns / 1ps
`default_nettype none
module gld_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tuser,
    output logic               item_valid,
    input  wire logic          item_ready,
    output gld_pkg::item_t     item
);
    gld_pkg::item_t queue_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign s_tready   = count_reg != 2'd2;
    assign item_valid = count_reg != 2'd0;
    assign item       = queue_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg].is_term   <= s_tuser;
            queue_reg[wr_ptr_reg].data_byte <= s_tdata;
        end
    end
endmodule
`default_nettype wire

// ===== sv/gld_core.sv =====
// Decoder core: code extraction, dictionary walk, string stack and result output.
`timescale 1ns / 1ps
`default_nettype none
module gld_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [22:0]         cfg_data,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire gld_pkg::item_t      item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gld_pkg::result_t         out_result,
    output logic                     out_last
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DRAIN, ST_POP, ST_CODE, ST_WALK, ST_WALKD, ST_FIN, ST_AFTER, ST_END
    } state_t;

    localparam int CB = gld_pkg::CODE_BITS;
    localparam int TB = gld_pkg::TABLE_BITS;

    state_t                 state_reg;
    logic [3:0]             min_size_reg;
    logic [22:0]            limit_reg;
    logic [19:0]            buf_reg;
    logic [4:0]             cnt_reg;
    logic [3:0]             cw_reg;
    logic [CB-1:0]          next_reg;
    logic [CB-1:0]          prev_reg;
    logic [7:0]             fc_reg;
    logic                   aclr_reg;
    logic [22:0]            pc_reg;
    logic                   fin_reg;
    logic [CB-1:0]          fill_reg;
    logic [6:0]             n_reg;
    logic                   phase_reg;
    logic                   busy_reg;
    gld_pkg::item_t         item_reg;
    logic [CB-1:0]          code_reg;
    logic [CB-1:0]          c_reg;
    logic                   held_valid_reg;
    gld_pkg::result_t       held_reg;
    logic                   out_valid_reg;
    gld_pkg::result_t       out_reg;
    logic                   out_last_reg;

    logic [7:0]             stack_mem [gld_pkg::TABLE_ENTRIES];
    logic [CB-1:0]          prefix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0]             suffix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0]             stack_rd_reg;
    logic [CB-1:0]          pre_rd_reg;
    logic [7:0]             suf_rd_reg;

    logic [3:0]             eff_min;
    logic [3:0]             cfg_eff_min;
    logic [CB-1:0]          clear_code;
    logic [CB-1:0]          end_code;
    logic [CB-1:0]          code_mask;
    logic [CB-1:0]          code_ext;
    logic                   code_ready;
    logic                   pend;
    logic                   out_free;
    logic                   n_full;
    logic                   walk_more;
    logic                   is_bad;
    logic [23:0]            pc_sum;
    logic                   emit_req;
    logic                   emit_ok;
    gld_pkg::result_t       emit_res;
    logic                   stack_we;
    logic [TB-1:0]          stack_wa;
    logic [7:0]             stack_wd;
    logic [TB-1:0]          stack_ra;
    logic                   dict_we;

    assign eff_min     = (min_size_reg > 4'd8) ? 4'd8 : min_size_reg;
    assign cfg_eff_min = (cfg_data[3:0] > 4'd8) ? 4'd8 : cfg_data[3:0];
    assign clear_code  = CB'(1) << eff_min;
    assign end_code    = clear_code + CB'(1);
    assign code_mask   = (CB'(1) << cw_reg) - CB'(1);
    assign code_ext    = {1'b0, buf_reg[11:0]} & code_mask;
    assign code_ready  = cnt_reg >= {1'b0, cw_reg};
    assign pend        = (fill_reg != '0) || (!fin_reg && code_ready);
    assign out_free    = !out_valid_reg || out_ready;
    assign n_full      = n_reg == 7'(gld_pkg::STEP_CAP);
    assign walk_more   = (c_reg > end_code) && (c_reg < CB'(gld_pkg::TABLE_ENTRIES));
    assign is_bad      = (code_reg > next_reg) || (code_reg >= CB'(gld_pkg::TABLE_ENTRIES))
                         || ((code_reg == next_reg) && aclr_reg);
    assign pc_sum      = {1'b0, pc_reg} + {11'd0, fill_reg};
    assign stack_ra    = fill_reg[TB-1:0] - TB'(1);

    assign item_ready  = state_reg == ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign out_result  = out_reg;
    assign out_last    = out_last_reg;

    always_comb begin
        emit_req = 1'b0;
        emit_res = '{status: gld_pkg::STATUS_PIXEL, pixel_value: 8'd0,
                     pixel_index: pc_reg[gld_pkg::PIXEL_INDEX_BITS-1:0]};
        stack_we = 1'b0;
        stack_wa = fill_reg[TB-1:0];
        stack_wd = c_reg[7:0];
        dict_we  = 1'b0;
        unique case (state_reg)
            ST_POP: begin
                emit_req = 1'b1;
                emit_res.pixel_value = stack_rd_reg;
                emit_res.pixel_index = 22'(pc_reg - {10'd0, fill_reg});
            end
            ST_CODE: begin
                if (code_reg == end_code) begin
                    emit_req = 1'b1;
                    emit_res.status = gld_pkg::STATUS_FINISHED;
                end else if (code_reg != clear_code && is_bad) begin
                    emit_req = 1'b1;
                    emit_res.status = gld_pkg::STATUS_BAD_CODE;
                end else if (code_reg != clear_code && code_reg == next_reg) begin
                    stack_we = 1'b1;
                    stack_wa = '0;
                    stack_wd = fc_reg;
                end
            end
            ST_WALK: begin
                stack_we = !walk_more;
            end
            ST_WALKD: begin
                stack_we = 1'b1;
                stack_wd = suf_rd_reg;
            end
            ST_FIN: begin
                dict_we = !aclr_reg && (next_reg < CB'(gld_pkg::TABLE_ENTRIES));
            end
            ST_AFTER: begin
                if (!fin_reg && item_reg.is_term && !busy_reg && !n_full) begin
                    emit_req = 1'b1;
                    emit_res.status = gld_pkg::STATUS_FINISHED;
                end
            end
            default: begin
            end
        endcase
    end

    assign emit_ok = emit_req && (!held_valid_reg || out_free);

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_rd_reg <= stack_mem[stack_ra];
    end

    always_ff @(posedge aclk) begin
        if (dict_we) begin
            prefix_mem[next_reg[TB-1:0]] <= prev_reg;
            suffix_mem[next_reg[TB-1:0]] <= fc_reg;
        end
        pre_rd_reg <= prefix_mem[c_reg[TB-1:0]];
        suf_rd_reg <= suffix_mem[c_reg[TB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_size_reg   <= 4'd8;
            limit_reg      <= '0;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            cw_reg         <= 4'd9;
            next_reg       <= CB'(258);
            prev_reg       <= gld_pkg::NO_CODE;
            fc_reg         <= '0;
            aclr_reg       <= 1'b1;
            pc_reg         <= '0;
            fin_reg        <= 1'b0;
            fill_reg       <= '0;
            n_reg          <= '0;
            phase_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit_ok) begin
                if (held_valid_reg) begin
                    out_reg       <= held_reg;
                    out_last_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                held_reg       <= emit_res;
                held_valid_reg <= 1'b1;
                n_reg          <= n_reg + 7'd1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        item_reg  <= item;
                        n_reg     <= '0;
                        phase_reg <= 1'b0;
                        busy_reg  <= pend;
                        state_reg <= fin_reg ? ST_IDLE : ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (n_full || (fill_reg == '0 && (fin_reg || !code_ready))) begin
                        state_reg <= phase_reg ? ST_END : ST_AFTER;
                    end else if (fill_reg != '0) begin
                        state_reg <= ST_POP;
                    end else begin
                        code_reg  <= code_ext;
                        buf_reg   <= buf_reg >> cw_reg;
                        cnt_reg   <= cnt_reg - {1'b0, cw_reg};
                        state_reg <= ST_CODE;
                    end
                end
                ST_POP: begin
                    if (emit_ok) begin
                        fill_reg  <= fill_reg - CB'(1);
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_CODE: begin
                    if (code_reg == clear_code) begin
                        cw_reg    <= eff_min + 4'd1;
                        next_reg  <= clear_code + CB'(2);
                        prev_reg  <= gld_pkg::NO_CODE;
                        aclr_reg  <= 1'b1;
                        state_reg <= ST_DRAIN;
                    end else if (code_reg == end_code || is_bad) begin
                        if (emit_ok) begin
                            fin_reg   <= 1'b1;
                            state_reg <= ST_DRAIN;
                        end
                    end else if (code_reg == next_reg) begin
                        fill_reg  <= CB'(1);
                        c_reg     <= prev_reg;
                        state_reg <= ST_WALK;
                    end else begin
                        fill_reg  <= '0;
                        c_reg     <= code_reg;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk_more) begin
                        state_reg <= ST_WALKD;
                    end else begin
                        fc_reg    <= c_reg[7:0];
                        fill_reg  <= fill_reg + CB'(1);
                        state_reg <= ST_FIN;
                    end
                end
                ST_WALKD: begin
                    fill_reg  <= fill_reg + CB'(1);
                    c_reg     <= pre_rd_reg;
                    state_reg <= ST_WALK;
                end
                ST_FIN: begin
                    if (pc_sum > {1'b0, limit_reg}) begin
                        fill_reg <= '0;
                    end else begin
                        pc_reg <= pc_sum[22:0];
                    end
                    if (dict_we) begin
                        next_reg <= next_reg + CB'(1);
                        if ((next_reg + CB'(1)) >= (CB'(1) << cw_reg)
                                && cw_reg < 4'(gld_pkg::MAX_CODE_BITS)) begin
                            cw_reg <= cw_reg + 4'd1;
                        end
                    end
                    prev_reg  <= code_reg;
                    aclr_reg  <= 1'b0;
                    state_reg <= ST_DRAIN;
                end
                ST_AFTER: begin
                    if (fin_reg) begin
                        state_reg <= ST_END;
                    end else if (item_reg.is_term) begin
                        if (!emit_req) begin
                            state_reg <= ST_END;
                        end else if (emit_ok) begin
                            fin_reg   <= 1'b1;
                            state_reg <= ST_END;
                        end
                    end else if (cnt_reg <= 5'd12) begin
                        buf_reg   <= buf_reg | (20'(item_reg.data_byte) << cnt_reg);
                        cnt_reg   <= cnt_reg + 5'd8;
                        phase_reg <= 1'b1;
                        state_reg <= ST_DRAIN;
                    end else begin
                        state_reg <= ST_END;
                    end
                end
                ST_END: begin
                    if (!held_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_reg        <= held_reg;
                        out_last_reg   <= !pend;
                        out_valid_reg  <= 1'b1;
                        held_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_we) begin
                if (cfg_index == gld_pkg::CFG_MIN_CODE_SIZE) begin
                    min_size_reg <= cfg_data[3:0];
                    cw_reg       <= cfg_eff_min + 4'd1;
                    next_reg     <= (CB'(1) << cfg_eff_min) + CB'(2);
                    prev_reg     <= gld_pkg::NO_CODE;
                    aclr_reg     <= 1'b1;
                end else begin
                    limit_reg <= cfg_data;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_gif_lzw_decoder.sv =====
// Self-checking testbench for the GIF LZW decoder, driven by generated code streams.
`timescale 1ns / 1ps
module tb_gif_lzw_decoder;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  value;
        logic [21:0] index;
        logic        last;
    } pixel_exp_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [22:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] end_of_data
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] pixel_value, [29:8] pixel_index, zero above
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    gif_lzw_decoder u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    gld_pkg::item_t byte_q[$];
    pixel_exp_t     pixel_q[$];
    int             errors = 0;
    int             idle_mode = 0;

    // Decoder mirror.
    logic [12:0] d_prefix[gld_pkg::TABLE_ENTRIES];
    logic [7:0]  d_suffix[gld_pkg::TABLE_ENTRIES];
    logic [7:0]  d_stack[gld_pkg::TABLE_ENTRIES + 2];
    int unsigned d_fill, d_bits, d_nbits, d_width, d_next, d_prev, d_count, d_min, d_limit;
    logic [7:0]  d_first;
    bit          d_fresh, d_done;
    int          d_n;

    // Stream generator state.
    longint unsigned g_bits;
    int unsigned     g_nbits, g_width, g_next, g_min;
    bit              g_fresh;

    function automatic int unsigned eff_min();
        return (d_min > 8) ? 8 : d_min;
    endfunction

    function automatic void restart_dict();
        d_width = eff_min() + 1;
        d_next = (1 << eff_min()) + 2;
        d_prev = gld_pkg::NO_CODE;
        d_fresh = 1'b1;
    endfunction

    function automatic void add_pixel(logic [1:0] st, logic [7:0] v, int unsigned idx);
        pixel_exp_t e;
        e.status = st;
        e.value = v;
        e.index = idx[21:0];
        e.last = 1'b0;
        pixel_q.push_back(e);
        d_n++;
    endfunction

    function automatic void push_stack(logic [7:0] v);
        if (d_fill < gld_pkg::TABLE_ENTRIES + 2) begin
            d_stack[d_fill] = v;
            d_fill++;
        end
    endfunction

    function automatic void expand_code(int unsigned code);
        int unsigned clr, eoi, c, steps, len;
        clr = 1 << eff_min();
        eoi = clr + 1;
        if (code == eoi) begin
            add_pixel(gld_pkg::STATUS_FINISHED, 8'd0, d_count);
            d_done = 1'b1;
            return;
        end
        if (code == clr) begin
            restart_dict();
            return;
        end
        if (code > d_next || code >= gld_pkg::TABLE_ENTRIES || (code == d_next && d_fresh)) begin
            add_pixel(gld_pkg::STATUS_BAD_CODE, 8'd0, d_count);
            d_done = 1'b1;
            return;
        end
        d_fill = 0;
        c = code;
        if (code == d_next) begin
            push_stack(d_first);
            c = d_prev;
        end
        steps = 0;
        while (c > eoi && c < gld_pkg::TABLE_ENTRIES && steps < gld_pkg::TABLE_ENTRIES) begin
            push_stack(d_suffix[c]);
            c = d_prefix[c];
            steps++;
        end
        push_stack(c[7:0]);
        len = d_fill;
        d_first = d_stack[len - 1];
        if (longint'(d_count) + len > longint'(d_limit)) d_fill = 0;
        else d_count += len;
        if (!d_fresh && d_next < gld_pkg::TABLE_ENTRIES) begin
            d_prefix[d_next] = d_prev[12:0];
            d_suffix[d_next] = d_first;
            d_next++;
            if (d_next >= (1 << d_width) && d_width < gld_pkg::MAX_CODE_BITS) d_width++;
        end
        d_prev = code;
        d_fresh = 1'b0;
    endfunction

    function automatic bit work_left();
        return d_fill > 0 || (!d_done && d_nbits >= d_width);
    endfunction

    function automatic void drain_work();
        int unsigned code;
        while (d_n < gld_pkg::STEP_CAP) begin
            if (d_fill > 0) begin
                d_fill--;
                add_pixel(gld_pkg::STATUS_PIXEL, d_stack[d_fill], d_count - d_fill - 1);
            end else if (!d_done && d_nbits >= d_width) begin
                code = d_bits & ((1 << d_width) - 1);
                d_bits >>= d_width;
                d_nbits -= d_width;
                expand_code(code);
            end else begin
                break;
            end
        end
    endfunction

    function automatic void decode_beat(gld_pkg::item_t it);
        bit busy;
        if (d_done) return;
        d_n = 0;
        busy = work_left();
        drain_work();
        if (!d_done) begin
            if (it.is_term) begin
                if (!busy && d_n < gld_pkg::STEP_CAP) begin
                    add_pixel(gld_pkg::STATUS_FINISHED, 8'd0, d_count);
                    d_done = 1'b1;
                end
            end else if (d_nbits <= 12) begin
                d_bits |= int'(it.data_byte) << d_nbits;
                d_nbits += 8;
                drain_work();
            end
        end
        if (d_n > 0) pixel_q[pixel_q.size() - 1].last = !work_left();
    endfunction

    function automatic void gen_restart();
        g_width = g_min + 1;
        g_next = (1 << g_min) + 2;
        g_fresh = 1'b1;
    endfunction

    function automatic void push_code(int unsigned code);
        gld_pkg::item_t it;
        g_bits |= longint'(code) << g_nbits;
        g_nbits += g_width;
        while (g_nbits >= 8) begin
            it.is_term = 1'b0;
            it.data_byte = g_bits[7:0];
            byte_q.push_back(it);
            g_bits >>= 8;
            g_nbits -= 8;
        end
        if (code == (1 << g_min)) begin
            gen_restart();
        end else begin
            if (!g_fresh && g_next < gld_pkg::TABLE_ENTRIES) begin
                g_next++;
                if (g_next >= (1 << g_width) && g_width < gld_pkg::MAX_CODE_BITS) g_width++;
            end
            g_fresh = 1'b0;
        end
    endfunction

    function automatic void random_code();
        int unsigned r, clr, top;
        r = $urandom_range(0, 99);
        clr = 1 << g_min;
        top = (1 << g_width) - 1;
        if (r < 4 && !g_fresh) push_code(clr);
        else if (r < 20 && !g_fresh && g_next <= top) push_code(g_next);
        else if (r < 65 && g_next > clr + 2)
            push_code($urandom_range(clr + 2, (g_next - 1 < top) ? g_next - 1 : top));
        else push_code($urandom_range(0, clr - 1));
    endfunction

    function automatic void align_stream();
        while (g_nbits != 0) push_code(1 << g_min);
    endfunction

    task automatic wait_idle();
        while (byte_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge aclk);
        repeat (20000) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[22:0];
        if (idx == gld_pkg::CFG_MIN_CODE_SIZE) begin
            d_min = val & 4'hF;
            restart_dict();
            g_min = (d_min > 8) ? 8 : d_min;
            gen_restart();
        end else begin
            d_limit = val & 23'h7FFFFF;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_stream(int mode, int nbytes);
        int start;
        idle_mode = mode;
        start = byte_q.size();
        while (byte_q.size() - start < nbytes) random_code();
        align_stream();
        wait_idle();
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Beat source.
    gld_pkg::item_t cur_item;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) decode_beat(cur_item);
            if (byte_q.size() != 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 13) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 69)) begin
                cur_item = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= cur_item.data_byte;
                s_tuser <= cur_item.is_term;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Result sink.
    always @(posedge aclk) begin
        pixel_exp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected beat status", m_tuser, 0);
                end else begin
                    e = pixel_q.pop_front();
                    if (m_tuser != e.status) report("status", m_tuser, e.status);
                    if (m_tdata[7:0] != e.value) report("pixel_value", m_tdata[7:0], e.value);
                    if (m_tdata[29:8] != e.index) report("pixel_index", m_tdata[29:8], e.index);
                    if (m_tlast != e.last) report("last_of_run", m_tlast, e.last);
                end
            end
            if (idle_mode == 0) m_tready <= $urandom_range(0, 99) >= 69;
            else if (idle_mode == 1) m_tready <= $urandom_range(0, 99) >= 13;
            else m_tready <= 1'b1;
        end
    end

    initial begin
        gld_pkg::item_t term;
        int             ending;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gld_pkg::CFG_MIN_CODE_SIZE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        for (int i = 0; i < gld_pkg::TABLE_ENTRIES; i++) begin
            d_prefix[i] = (i < 258) ? gld_pkg::NO_CODE : '0;
            d_suffix[i] = (i < 258) ? i[7:0] : '0;
        end
        d_min = 8;
        d_limit = 0;
        d_fill = 0;
        d_bits = 0;
        d_nbits = 0;
        d_first = '0;
        d_count = 0;
        d_done = 1'b0;
        restart_dict();
        g_min = 8;
        g_bits = 0;
        g_nbits = 0;
        gen_restart();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a pixel limit of zero drops every string.
        idle_mode = 0;
        push_code(0);
        push_code(255);
        push_code(258);
        align_stream();
        wait_idle();

        // A limit of 4194304, then roots at both ends, a repeated-string code and a clear.
        write_reg(gld_pkg::CFG_PIXEL_LIMIT, 4194304);
        write_reg(gld_pkg::CFG_MIN_CODE_SIZE, 8);
        push_code(256);
        push_code(0);
        push_code(255);
        push_code(259);
        push_code(258);
        push_code(260);
        push_code(256);
        push_code(128);
        push_code(127);
        align_stream();
        wait_idle();

        write_reg(gld_pkg::CFG_MIN_CODE_SIZE, 2);
        random_stream(0, 40);
        write_reg(gld_pkg::CFG_MIN_CODE_SIZE, 0);
        write_reg(gld_pkg::CFG_PIXEL_LIMIT, d_count + $urandom_range(20, 60));
        random_stream(1, 30);
        write_reg(gld_pkg::CFG_PIXEL_LIMIT, 4194303);
        write_reg(gld_pkg::CFG_MIN_CODE_SIZE, 15);
        random_stream(2, 40);
        write_reg(gld_pkg::CFG_MIN_CODE_SIZE, $urandom_range(1, 7));
        random_stream(2, 30);

        // Close the image by end code, by a bad code, or by the terminator alone.
        idle_mode = 2;
        ending = $urandom_range(0, 2);
        if (ending == 0) begin
            push_code((1 << g_min) + 1);
        end else if (ending == 1) begin
            push_code(1 << g_min);
            push_code((1 << g_min) + 2);
        end
        while (g_nbits != 0) push_code(ending == 2 ? (1 << g_min) : 0);
        term.is_term = 1'b1;
        term.data_byte = 8'hFF;
        byte_q.push_back(term);
        byte_q.push_back(term);
        term.is_term = 1'b0;
        term.data_byte = 8'h00;
        byte_q.push_back(term);
        wait_idle();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/gld_pkg.sv
sv/gld_front.sv
sv/gld_core.sv
sv/gif_lzw_decoder.sv
sim/tb_gif_lzw_decoder.sv
